>>> rtl/core/atsf_pkg.sv
`timescale 1ns / 1ps

package atsf_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_OPEN_DIR      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RUN_DUTY      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_ENC_DELTA = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STALL_TMO     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_START_GRACE   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_TMO   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CLOSE_TMO     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_OPEN_TMO      = 3'd7;

    localparam int DUTY_W  = 7;
    localparam int MODE_W  = 3;
    localparam int FAULT_W = 4;
    localparam int CMD_W   = 3;
    localparam int LIMIT_W = 3;
    localparam int ACT_W   = 2;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

    // commands
    localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_OPEN  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLOSE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

    // limit switch codes
    localparam logic [LIMIT_W-1:0] LIM_NONE     = 3'd0;
    localparam logic [LIMIT_W-1:0] LIM_OPEN     = 3'd1;
    localparam logic [LIMIT_W-1:0] LIM_CLOSE    = 3'd2;
    localparam logic [LIMIT_W-1:0] LIM_CONFLICT = 3'd3;

    // fault codes
    localparam logic [FAULT_W-1:0] F_NONE        = 4'd0;
    localparam logic [FAULT_W-1:0] F_LIMIT       = 4'd1;
    localparam logic [FAULT_W-1:0] F_CONFLICT    = 4'd2;
    localparam logic [FAULT_W-1:0] F_ENCODER     = 4'd3;
    localparam logic [FAULT_W-1:0] F_COMMAND     = 4'd4;
    localparam logic [FAULT_W-1:0] F_CLOSE_STUCK = 4'd5;
    localparam logic [FAULT_W-1:0] F_OPEN_STUCK  = 4'd6;
    localparam logic [FAULT_W-1:0] F_OPEN_TMO    = 4'd7;
    localparam logic [FAULT_W-1:0] F_CLOSE_TMO   = 4'd8;
    localparam logic [FAULT_W-1:0] F_STALL       = 4'd9;
    localparam logic [FAULT_W-1:0] F_OPEN_LOST   = 4'd10;
    localparam logic [FAULT_W-1:0] F_CLOSE_LOST  = 4'd11;
    localparam logic [FAULT_W-1:0] F_DRIVER      = 4'd12;

    // motor actions
    localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_STOP  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_START = 2'd2;
    localparam logic [ACT_W-1:0] ACT_SAFE  = 2'd3;

    // motor request raised by one tick before the driver check
    typedef enum logic [1:0] {
        REQ_NONE,
        REQ_STOP,
        REQ_FAULT,
        REQ_START
    } req_kind_t;

endpackage

>>> rtl/core/actuator_travel_safety_fsm.sv
`timescale 1ns / 1ps

// channel   | dir | handshake          | payload
// ----------+-----+--------------------+---------------------------------------------
// s_        | in  | s_tvalid/s_tready  | s_tdata: one control tick
// m_        | out | m_tvalid/m_tready  | m_tdata: status, mode, fault, motor request
// cfg_      | in  | cfg_valid/cfg_ready| cfg_index, cfg_data: register write
//
// a tick is captured in an input register, evaluated combinationally and lands in
// the result register; one tick per cycle is sustained while results are taken.
// the mode/fault/reference registers update together with the result register.
// a full result register that is not taken holds the input register; s_tready
// stays high while the input register can move on. cfg_ready is always high.
// aresetn is synchronous; the configuration returns to its default values.

module actuator_travel_safety_fsm #(
    parameter int TIME_BITS = 32,
    parameter int POS_BITS  = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // cmd, limit_read_ok, limit_settled, limit_code, encoder_ok, encoder_count,
    // time_ms, driver_ok, zero pad
    input  logic [((10+POS_BITS+TIME_BITS+7)/8)*8-1:0] s_tdata,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // step_status, mode, fault_code, motor_action, motor_dir, motor_duty, zero pad
    output logic [23:0]                       m_tdata,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [atsf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [atsf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import atsf_pkg::*;

    localparam int IN_BITS  = 10 + POS_BITS + TIME_BITS;
    localparam int OUT_BITS = 18;
    localparam int POS_LSB  = 9;
    localparam int TIME_LSB = POS_LSB + POS_BITS;
    localparam int DRV_BIT  = TIME_LSB + TIME_BITS;
    localparam int TCMP_W   = (TIME_BITS > CFG_DATA_W) ? TIME_BITS : CFG_DATA_W;
    localparam int PCMP_W   = (POS_BITS > CFG_DATA_W) ? POS_BITS : CFG_DATA_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_INIT     = 3'd0,
        MODE_IDLE     = 3'd1,
        MODE_MV_OPEN  = 3'd2,
        MODE_MV_CLOSE = 3'd3,
        MODE_AT_OPEN  = 3'd4,
        MODE_AT_CLOSE = 3'd5,
        MODE_FAULT    = 3'd6
    } mode_t;

    // configuration
    logic                  open_dir_reg;
    logic [DUTY_W-1:0]     run_duty_reg;
    logic [CFG_DATA_W-1:0] min_delta_reg;
    logic [CFG_DATA_W-1:0] stall_tmo_reg;
    logic [CFG_DATA_W-1:0] grace_reg;
    logic [CFG_DATA_W-1:0] release_tmo_reg;
    logic [CFG_DATA_W-1:0] close_tmo_reg;
    logic [CFG_DATA_W-1:0] open_tmo_reg;

    // tick state
    mode_t                 mode_reg, mode_next;
    logic [FAULT_W-1:0]    fault_reg, fault_next;
    logic [TIME_BITS-1:0]  motion_start_reg, motion_start_next;
    logic [TIME_BITS-1:0]  last_move_reg, last_move_next;
    logic [POS_BITS-1:0]   ref_pos_reg, ref_pos_next;

    // pipeline
    logic                  in_valid_reg;
    logic [IN_BITS-1:0]    in_data_reg;
    logic                  out_valid_reg;
    logic [OUT_BITS-1:0]   out_data_reg, out_data_next;
    logic                  fire;

    // unpacked tick
    logic [CMD_W-1:0]      cmd;
    logic                  read_ok;
    logic                  settled;
    logic [LIMIT_W-1:0]    lc;
    logic                  enc_ok;
    logic [POS_BITS-1:0]   pos;
    logic [TIME_BITS-1:0]  now;
    logic                  drv_ok;

    // datapath terms
    logic [TIME_BITS-1:0]  elapsed;
    logic [TIME_BITS-1:0]  since_move;
    logic [POS_BITS-1:0]   pos_diff;
    logic                  moved;
    logic                  stall_due;
    logic [DUTY_W-1:0]     duty_sat;

    // request resolution
    req_kind_t             req;
    logic [FAULT_W-1:0]    req_fault;
    mode_t                 req_mode;
    logic                  req_dir;
    logic                  upd_ref;
    logic                  status;
    logic [ACT_W-1:0]      action;
    logic                  dir_out;
    logic [DUTY_W-1:0]     duty_out;

    assign cmd     = in_data_reg[2:0];
    assign read_ok = in_data_reg[3];
    assign settled = in_data_reg[4];
    assign lc      = in_data_reg[7:5];
    assign enc_ok  = in_data_reg[8];
    assign pos     = in_data_reg[POS_LSB +: POS_BITS];
    assign now     = in_data_reg[TIME_LSB +: TIME_BITS];
    assign drv_ok  = in_data_reg[DRV_BIT];

    assign fire      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || fire;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(24-OUT_BITS){1'b0}}, out_data_reg};
    assign cfg_ready = 1'b1;

    assign elapsed    = now - motion_start_reg;
    assign since_move = now - last_move_reg;
    // signed compare picks the order, the difference then fits unsigned
    assign pos_diff   = ($signed(pos) >= $signed(ref_pos_reg)) ? (pos - ref_pos_reg)
                                                              : (ref_pos_reg - pos);
    assign moved      = PCMP_W'(pos_diff) >= PCMP_W'(min_delta_reg);
    assign stall_due  = TCMP_W'(since_move) >= TCMP_W'(stall_tmo_reg);
    assign duty_sat   = (run_duty_reg > DUTY_MAX) ? DUTY_MAX : run_duty_reg;

    // decide what this tick asks of the motor
    always_comb begin
        logic to_open;
        logic at_open;
        logic [LIMIT_W-1:0] arrive;
        logic [LIMIT_W-1:0] depart;
        logic [CMD_W-1:0]   same_cmd;
        logic [CMD_W-1:0]   back_cmd;
        logic stall_hit;

        to_open   = (mode_reg == MODE_MV_OPEN);
        at_open   = (mode_reg == MODE_AT_OPEN);
        arrive    = to_open ? LIM_OPEN : LIM_CLOSE;
        depart    = to_open ? LIM_CLOSE : LIM_OPEN;
        same_cmd  = to_open ? CMD_OPEN : CMD_CLOSE;
        back_cmd  = to_open ? CMD_CLOSE : CMD_OPEN;
        stall_hit = 1'b0;
        req       = REQ_NONE;
        req_fault = F_NONE;
        req_mode  = mode_reg;
        req_dir   = 1'b0;
        upd_ref   = 1'b0;

        if (!read_ok && mode_reg != MODE_FAULT) begin
            req       = REQ_FAULT;
            req_fault = F_LIMIT;
        end else if (mode_reg != MODE_FAULT && settled && lc == LIM_CONFLICT) begin
            req       = REQ_FAULT;
            req_fault = F_CONFLICT;
        end else begin
            case (mode_reg)
                MODE_INIT: begin
                    if (settled) begin
                        if (lc == LIM_NONE) begin
                            req_mode = MODE_IDLE;
                        end else if (lc == LIM_OPEN) begin
                            req_mode = MODE_AT_OPEN;
                        end else if (lc == LIM_CLOSE) begin
                            req_mode = MODE_AT_CLOSE;
                        end else begin
                            req       = REQ_FAULT;
                            req_fault = F_LIMIT;
                        end
                    end
                end
                MODE_IDLE: begin
                    if (cmd == CMD_STOP) begin
                        req = REQ_STOP;
                    end else if (cmd == CMD_OPEN || cmd == CMD_CLOSE) begin
                        if (!enc_ok) begin
                            req       = REQ_FAULT;
                            req_fault = F_ENCODER;
                        end else begin
                            req      = REQ_START;
                            req_dir  = (cmd == CMD_OPEN) ? open_dir_reg : !open_dir_reg;
                            req_mode = (cmd == CMD_OPEN) ? MODE_MV_OPEN : MODE_MV_CLOSE;
                        end
                    end else if (cmd > CMD_CLEAR) begin
                        req       = REQ_FAULT;
                        req_fault = F_COMMAND;
                    end
                end
                MODE_MV_OPEN, MODE_MV_CLOSE: begin
                    if (!enc_ok) begin
                        req       = REQ_FAULT;
                        req_fault = F_ENCODER;
                    end else if (settled && lc == arrive) begin
                        req      = REQ_STOP;
                        req_mode = to_open ? MODE_AT_OPEN : MODE_AT_CLOSE;
                    end else if (settled && lc == depart &&
                                 TCMP_W'(elapsed) >= TCMP_W'(release_tmo_reg)) begin
                        req       = REQ_FAULT;
                        req_fault = to_open ? F_CLOSE_STUCK : F_OPEN_STUCK;
                    end else if (TCMP_W'(elapsed) >=
                                 TCMP_W'(to_open ? open_tmo_reg : close_tmo_reg)) begin
                        req       = REQ_FAULT;
                        req_fault = to_open ? F_OPEN_TMO : F_CLOSE_TMO;
                    end else begin
                        // encoder watch, skipped during the startup grace window
                        if (TCMP_W'(elapsed) <= TCMP_W'(grace_reg) || moved) begin
                            upd_ref = 1'b1;
                        end else if (stall_due) begin
                            stall_hit = 1'b1;
                            req       = REQ_FAULT;
                            req_fault = F_STALL;
                        end
                        if (!stall_hit) begin
                            if (cmd == CMD_NONE || cmd == CMD_CLEAR || cmd == same_cmd) begin
                                req = REQ_NONE;
                            end else if (cmd == CMD_STOP || cmd == back_cmd) begin
                                req      = REQ_STOP;
                                req_mode = MODE_IDLE;
                            end else begin
                                req       = REQ_FAULT;
                                req_fault = F_COMMAND;
                            end
                        end
                    end
                end
                MODE_AT_OPEN, MODE_AT_CLOSE: begin
                    if (settled && lc != (at_open ? LIM_OPEN : LIM_CLOSE)) begin
                        req       = REQ_FAULT;
                        req_fault = at_open ? F_OPEN_LOST : F_CLOSE_LOST;
                    end else if (cmd == (at_open ? CMD_CLOSE : CMD_OPEN)) begin
                        if (!enc_ok) begin
                            req       = REQ_FAULT;
                            req_fault = F_ENCODER;
                        end else begin
                            req      = REQ_START;
                            req_dir  = at_open ? !open_dir_reg : open_dir_reg;
                            req_mode = at_open ? MODE_MV_CLOSE : MODE_MV_OPEN;
                        end
                    end else if (cmd == CMD_STOP) begin
                        req = REQ_STOP;
                    end else if (cmd > CMD_CLEAR) begin
                        req       = REQ_FAULT;
                        req_fault = F_COMMAND;
                    end
                end
                default: begin
                    req = REQ_NONE;
                end
            endcase
        end
    end

    // driver check and state update
    always_comb begin
        mode_next         = req_mode;
        fault_next        = fault_reg;
        motion_start_next = motion_start_reg;
        last_move_next    = upd_ref ? now : last_move_reg;
        ref_pos_next      = upd_ref ? pos : ref_pos_reg;
        status            = 1'b0;
        action            = ACT_NONE;
        dir_out           = 1'b0;
        duty_out          = '0;

        if (req != REQ_NONE && !drv_ok) begin
            // driver refusal overrides any latched fault
            status     = 1'b1;
            action     = ACT_SAFE;
            mode_next  = MODE_FAULT;
            fault_next = F_DRIVER;
        end else begin
            case (req)
                REQ_STOP: begin
                    action = ACT_STOP;
                end
                REQ_FAULT: begin
                    action    = ACT_STOP;
                    mode_next = MODE_FAULT;
                    if (fault_reg == F_NONE) begin
                        fault_next = req_fault;
                    end
                end
                REQ_START: begin
                    action            = ACT_START;
                    dir_out           = req_dir;
                    duty_out          = duty_sat;
                    ref_pos_next      = pos;
                    last_move_next    = now;
                    motion_start_next = now;
                end
                default: begin
                    action = ACT_NONE;
                end
            endcase
        end

        out_data_next = {duty_out, dir_out, action, fault_next, mode_next, status};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_dir_reg     <= 1'b0;
            run_duty_reg     <= 7'd80;
            min_delta_reg    <= 32'd2;
            stall_tmo_reg    <= 32'd500;
            grace_reg        <= 32'd200;
            release_tmo_reg  <= 32'd1000;
            close_tmo_reg    <= 32'd10000;
            open_tmo_reg     <= 32'd10000;
            mode_reg         <= MODE_INIT;
            fault_reg        <= F_NONE;
            motion_start_reg <= '0;
            last_move_reg    <= '0;
            ref_pos_reg      <= '0;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_OPEN_DIR:      open_dir_reg    <= cfg_data[0];
                    REG_RUN_DUTY:      run_duty_reg    <= cfg_data[DUTY_W-1:0];
                    REG_MIN_ENC_DELTA: min_delta_reg   <= cfg_data;
                    REG_STALL_TMO:     stall_tmo_reg   <= cfg_data;
                    REG_START_GRACE:   grace_reg       <= cfg_data;
                    REG_RELEASE_TMO:   release_tmo_reg <= cfg_data;
                    REG_CLOSE_TMO:     close_tmo_reg   <= cfg_data;
                    REG_OPEN_TMO:      open_tmo_reg    <= cfg_data;
                    default:           open_dir_reg    <= open_dir_reg;
                endcase
            end

            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end

            if (fire) begin
                out_valid_reg    <= 1'b1;
                mode_reg         <= mode_next;
                fault_reg        <= fault_next;
                motion_start_reg <= motion_start_next;
                last_move_reg    <= last_move_next;
                ref_pos_reg      <= ref_pos_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata[IN_BITS-1:0];
        end
        if (fire) begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    a_fault_mode_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_FAULT) |=> (mode_reg == MODE_FAULT))
        else $error("fault mode was left");

    a_fault_code_latched: assert property (@(posedge aclk) disable iff (!aresetn)
        (fault_reg != F_NONE) |=> (fault_reg == $past(fault_reg) || fault_reg == F_DRIVER))
        else $error("latched fault code replaced by a non-driver fault");

    a_driver_error_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg[0]) |->
            (out_data_reg[3:1] == MODE_FAULT && out_data_reg[7:4] == F_DRIVER &&
             out_data_reg[9:8] == ACT_SAFE))
        else $error("driver error result inconsistent");

    a_start_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg[9:8] != ACT_START) |->
            (out_data_reg[10] == 1'b0 && out_data_reg[17:11] == '0))
        else $error("direction or duty set without a start");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input held off without a blocked result");
`endif

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
    import atsf_pkg::*;

    localparam int S_W          = ((10 + 32 + 32 + 7) / 8) * 8;
    localparam int LIMIT_CYCLES = 200000;

    // command and limit codes past the defined ones
    localparam logic [CMD_W-1:0]   CMD_FIRST_BAD = 3'd5;
    localparam logic [CMD_W-1:0]   CMD_LAST_BAD  = 3'd7;
    localparam logic [LIMIT_W-1:0] LIM_FIRST_BAD = 3'd4;
    localparam logic [LIMIT_W-1:0] LIM_LAST_BAD  = 3'd7;

    typedef enum logic [2:0] {
        MD_INIT,
        MD_IDLE,
        MD_MV_OPEN,
        MD_MV_CLOSE,
        MD_AT_OPEN,
        MD_AT_CLOSE,
        MD_FAULT
    } act_mode_t;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic               read_ok;
        logic               settled;
        logic [LIMIT_W-1:0] lc;
        logic               enc_ok;
        logic [31:0]        enc;
        logic [31:0]        now_ms;
        logic               drv_ok;
    } tick_t;

    typedef struct {
        act_mode_t          mode;
        logic [FAULT_W-1:0] fault;
        logic [31:0]        motion_start;
        logic [31:0]        last_move;
        logic [31:0]        ref_pos;
    } act_state_t;

    typedef struct {
        logic               status;
        act_mode_t          mode;
        logic [FAULT_W-1:0] fault;
        logic [ACT_W-1:0]   action;
        logic               dir;
        logic [DUTY_W-1:0]  duty;
    } step_res_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_W-1:0]         s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [23:0]            m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // configuration as the block should hold it
    logic              open_dir_r   = 1'b0;
    logic [DUTY_W-1:0] duty_r       = 7'd80;
    logic [31:0]       min_delta_r  = 32'd2;
    logic [31:0]       stall_ms_r   = 32'd500;
    logic [31:0]       grace_ms_r   = 32'd200;
    logic [31:0]       release_ms_r = 32'd1000;
    logic [31:0]       close_tmo_r  = 32'd10000;
    logic [31:0]       open_tmo_r   = 32'd10000;

    act_state_t  fsm_model;
    step_res_t   expected_steps[$];

    // stimulus-side time and encoder position; time starts just short of the wrap
    logic [31:0] clk_ms  = 32'hFFFF_FE00;
    logic [31:0] enc_pos = '0;

    int idle_pct  = 0;
    int stall_pct = 0;
    int err_cnt   = 0;
    int cycles    = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    actuator_travel_safety_fsm u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    function automatic void advance_actuator(input act_state_t s, input tick_t t,
                                             output act_state_t n, output step_res_t r);
        req_kind_t          req;
        logic [FAULT_W-1:0] f;
        act_mode_t          next_m;
        logic               d;
        logic               to_open;
        logic               stalled;
        logic [LIMIT_W-1:0] arrive;
        logic [LIMIT_W-1:0] depart;
        logic [31:0]        el;
        logic signed [32:0] dp;
        logic [32:0]        moved;
        n        = s;
        r.status = 1'b0;
        r.action = ACT_NONE;
        r.dir    = 1'b0;
        r.duty   = '0;
        req      = REQ_NONE;
        f        = F_NONE;
        next_m   = s.mode;
        d        = 1'b0;
        if (!t.read_ok && s.mode != MD_FAULT) begin
            req = REQ_FAULT;
            f   = F_LIMIT;
        end else if (s.mode != MD_FAULT && t.settled && t.lc == LIM_CONFLICT) begin
            req = REQ_FAULT;
            f   = F_CONFLICT;
        end else begin
            case (s.mode)
                MD_INIT: begin
                    if (t.settled) begin
                        if (t.lc == LIM_NONE) n.mode = MD_IDLE;
                        else if (t.lc == LIM_OPEN) n.mode = MD_AT_OPEN;
                        else if (t.lc == LIM_CLOSE) n.mode = MD_AT_CLOSE;
                        else begin
                            req = REQ_FAULT;
                            f   = F_LIMIT;
                        end
                    end
                end
                MD_IDLE: begin
                    if (t.cmd == CMD_STOP) begin
                        req = REQ_STOP;
                    end else if (t.cmd == CMD_OPEN || t.cmd == CMD_CLOSE) begin
                        if (!t.enc_ok) begin
                            req = REQ_FAULT;
                            f   = F_ENCODER;
                        end else begin
                            req    = REQ_START;
                            d      = (t.cmd == CMD_OPEN) ? open_dir_r : ~open_dir_r;
                            next_m = (t.cmd == CMD_OPEN) ? MD_MV_OPEN : MD_MV_CLOSE;
                        end
                    end else if (t.cmd > CMD_CLEAR) begin
                        req = REQ_FAULT;
                        f   = F_COMMAND;
                    end
                end
                MD_MV_OPEN, MD_MV_CLOSE: begin
                    to_open = (s.mode == MD_MV_OPEN);
                    arrive  = to_open ? LIM_OPEN : LIM_CLOSE;
                    depart  = to_open ? LIM_CLOSE : LIM_OPEN;
                    el      = t.now_ms - s.motion_start;
                    if (!t.enc_ok) begin
                        req = REQ_FAULT;
                        f   = F_ENCODER;
                    end else if (t.settled && t.lc == arrive) begin
                        req    = REQ_STOP;
                        next_m = to_open ? MD_AT_OPEN : MD_AT_CLOSE;
                    end else if (t.settled && t.lc == depart && el >= release_ms_r) begin
                        req = REQ_FAULT;
                        f   = to_open ? F_CLOSE_STUCK : F_OPEN_STUCK;
                    end else if (el >= (to_open ? open_tmo_r : close_tmo_r)) begin
                        req = REQ_FAULT;
                        f   = to_open ? F_OPEN_TMO : F_CLOSE_TMO;
                    end else begin
                        stalled = 1'b0;
                        if (el <= grace_ms_r) begin
                            n.ref_pos   = t.enc;
                            n.last_move = t.now_ms;
                        end else begin
                            // exact distance between two signed counts
                            dp    = $signed({t.enc[31], t.enc}) - $signed({s.ref_pos[31], s.ref_pos});
                            moved = (dp < 0) ? -dp : dp;
                            if (moved >= {1'b0, min_delta_r}) begin
                                n.ref_pos   = t.enc;
                                n.last_move = t.now_ms;
                            end else if (t.now_ms - s.last_move >= stall_ms_r) begin
                                req     = REQ_FAULT;
                                f       = F_STALL;
                                stalled = 1'b1;
                            end
                        end
                        if (!stalled) begin
                            if (t.cmd == CMD_STOP || t.cmd == (to_open ? CMD_CLOSE : CMD_OPEN)) begin
                                req    = REQ_STOP;
                                next_m = MD_IDLE;
                            end else if (t.cmd > CMD_CLEAR) begin
                                req = REQ_FAULT;
                                f   = F_COMMAND;
                            end
                        end
                    end
                end
                MD_AT_OPEN, MD_AT_CLOSE: begin
                    to_open = (s.mode == MD_AT_OPEN);
                    if (t.settled && t.lc != (to_open ? LIM_OPEN : LIM_CLOSE)) begin
                        req = REQ_FAULT;
                        f   = to_open ? F_OPEN_LOST : F_CLOSE_LOST;
                    end else if (t.cmd == (to_open ? CMD_CLOSE : CMD_OPEN)) begin
                        if (!t.enc_ok) begin
                            req = REQ_FAULT;
                            f   = F_ENCODER;
                        end else begin
                            req    = REQ_START;
                            d      = to_open ? ~open_dir_r : open_dir_r;
                            next_m = to_open ? MD_MV_CLOSE : MD_MV_OPEN;
                        end
                    end else if (t.cmd == CMD_STOP) begin
                        req = REQ_STOP;
                    end else if (t.cmd > CMD_CLEAR) begin
                        req = REQ_FAULT;
                        f   = F_COMMAND;
                    end
                end
                default: ;
            endcase
        end
        // any motor request is refused by a failing driver
        if (req != REQ_NONE && !t.drv_ok) begin
            r.action = ACT_SAFE;
            r.status = 1'b1;
            n.mode   = MD_FAULT;
            n.fault  = F_DRIVER;
        end else begin
            case (req)
                REQ_STOP: begin
                    r.action = ACT_STOP;
                    n.mode   = next_m;
                end
                REQ_FAULT: begin
                    r.action = ACT_STOP;
                    n.mode   = MD_FAULT;
                    if (n.fault == F_NONE) n.fault = f;
                end
                REQ_START: begin
                    r.action       = ACT_START;
                    r.dir          = d;
                    r.duty         = (duty_r > DUTY_MAX) ? DUTY_MAX : duty_r;
                    n.ref_pos      = t.enc;
                    n.last_move    = t.now_ms;
                    n.motion_start = t.now_ms;
                    n.mode         = next_m;
                end
                default: ;
            endcase
        end
        r.mode  = n.mode;
        r.fault = n.fault;
    endfunction

    // result check first, then the prediction for a tick taken at this edge
    always @(posedge aclk) begin
        step_res_t  want;
        step_res_t  nxt_res;
        act_state_t nxt;
        tick_t      t;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_steps.size() == 0) begin
                    $error("result transfer with no tick pending: %h", m_tdata);
                    err_cnt++;
                end else begin
                    want = expected_steps.pop_front();
                    if (m_tdata[0] !== want.status) begin
                        $error("step_status: expected %0d, got %0d", want.status, m_tdata[0]);
                        err_cnt++;
                    end
                    if (m_tdata[3:1] !== want.mode) begin
                        $error("mode: expected %0d, got %0d", want.mode, m_tdata[3:1]);
                        err_cnt++;
                    end
                    if (m_tdata[7:4] !== want.fault) begin
                        $error("fault_code: expected %0d, got %0d", want.fault, m_tdata[7:4]);
                        err_cnt++;
                    end
                    if (m_tdata[9:8] !== want.action) begin
                        $error("motor_action: expected %0d, got %0d", want.action, m_tdata[9:8]);
                        err_cnt++;
                    end
                    if (m_tdata[10] !== want.dir) begin
                        $error("motor_dir: expected %0d, got %0d", want.dir, m_tdata[10]);
                        err_cnt++;
                    end
                    if (m_tdata[17:11] !== want.duty) begin
                        $error("motor_duty: expected %0d, got %0d", want.duty, m_tdata[17:11]);
                        err_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                t.cmd     = s_tdata[2:0];
                t.read_ok = s_tdata[3];
                t.settled = s_tdata[4];
                t.lc      = s_tdata[7:5];
                t.enc_ok  = s_tdata[8];
                t.enc     = s_tdata[40:9];
                t.now_ms  = s_tdata[72:41];
                t.drv_ok  = s_tdata[73];
                advance_actuator(fsm_model, t, nxt, nxt_res);
                fsm_model = nxt;
                expected_steps.push_back(nxt_res);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(1, 100) > stall_pct);
    end

    // called at a falling edge; returns at the edge that takes the transfer
    task automatic push_tick(input tick_t t);
        while ($urandom_range(1, 100) <= idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= {{(S_W - 74){1'b0}}, t.drv_ok, t.now_ms, t.enc, t.enc_ok,
                     t.lc, t.settled, t.read_ok, t.cmd};
        s_tvalid <= 1'b1;
        clk_ms  = t.now_ms;
        enc_pos = t.enc;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic dir_tick(input logic [CMD_W-1:0] cmd, input logic settled,
                            input logic [LIMIT_W-1:0] lc, input logic [31:0] enc,
                            input int dt, input logic drv_ok);
        tick_t t;
        @(negedge aclk);
        t.cmd     = cmd;
        t.read_ok = 1'b1;
        t.settled = settled;
        t.lc      = lc;
        t.enc_ok  = 1'b1;
        t.enc     = enc;
        t.now_ms  = clk_ms + dt;
        t.drv_ok  = drv_ok;
        push_tick(t);
    endtask

    function automatic tick_t random_tick();
        tick_t              t;
        int                 r;
        logic [LIMIT_W-1:0] home;
        r = $urandom_range(0, 99);
        if (r < 20) t.cmd = CMD_W'($urandom_range(CMD_OPEN, CMD_CLOSE));
        else if (r < 28) t.cmd = CMD_STOP;
        else if (r < 32) t.cmd = CMD_CLEAR;
        else if (r < 35) t.cmd = CMD_W'($urandom_range(CMD_FIRST_BAD, CMD_LAST_BAD));
        else t.cmd = CMD_NONE;
        r = $urandom_range(0, 99);
        case (fsm_model.mode)
            MD_INIT:     home = LIMIT_W'($urandom_range(LIM_NONE, LIM_CLOSE));
            MD_AT_OPEN:  home = LIM_OPEN;
            MD_AT_CLOSE: home = LIM_CLOSE;
            MD_MV_OPEN:  home = (r < 8) ? LIM_OPEN : (r < 12) ? LIM_CLOSE : LIM_NONE;
            MD_MV_CLOSE: home = (r < 8) ? LIM_CLOSE : (r < 12) ? LIM_OPEN : LIM_NONE;
            default:     home = LIM_NONE;
        endcase
        t.lc      = ($urandom_range(0, 99) < 15) ?
                    LIMIT_W'($urandom_range(LIM_NONE, LIM_LAST_BAD)) : home;
        t.read_ok = $urandom_range(0, 99) < 98;
        t.settled = $urandom_range(0, 99) < 85;
        t.enc_ok  = $urandom_range(0, 99) < 96;
        t.drv_ok  = $urandom_range(0, 99) < 95;
        r = $urandom_range(0, 99);
        t.now_ms = clk_ms + ((r < 4) ? $urandom_range(0, 5000) : $urandom_range(0, 250));
        r = $urandom_range(0, 99);
        if (r < 3) t.enc = $urandom;
        else if (r < 5) t.enc = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        else t.enc = enc_pos + $urandom_range(0, 60) - 30;
        return t;
    endfunction

    // retries random ticks until one keeps the actuator out of fault
    function automatic tick_t safe_tick();
        tick_t      t;
        act_state_t ns;
        step_res_t  nr;
        for (int i = 0; i < 10; i++) begin
            t = random_tick();
            advance_actuator(fsm_model, t, ns, nr);
            if (ns.mode != MD_FAULT) return t;
        end
        // arriving at the end switch or holding still is safe in every mode
        t.read_ok = 1'b1;
        t.settled = 1'b1;
        t.enc_ok  = 1'b1;
        t.drv_ok  = 1'b1;
        t.cmd     = CMD_NONE;
        case (fsm_model.mode)
            MD_MV_OPEN, MD_AT_OPEN:   t.lc = LIM_OPEN;
            MD_MV_CLOSE, MD_AT_CLOSE: t.lc = LIM_CLOSE;
            default:                  t.lc = LIM_NONE;
        endcase
        return t;
    endfunction

    task automatic run_ticks(input int n, input bit guarded);
        repeat (n) begin
            @(negedge aclk);
            push_tick(guarded ? safe_tick() : random_tick());
        end
    endtask

    task automatic wait_quiet();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_steps.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_OPEN_DIR:      open_dir_r   = val[0];
            REG_RUN_DUTY:      duty_r       = val[DUTY_W-1:0];
            REG_MIN_ENC_DELTA: min_delta_r  = val;
            REG_STALL_TMO:     stall_ms_r   = val;
            REG_START_GRACE:   grace_ms_r   = val;
            REG_RELEASE_TMO:   release_ms_r = val;
            REG_CLOSE_TMO:     close_tmo_r  = val;
            REG_OPEN_TMO:      open_tmo_r   = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_config(input logic dir, input logic [31:0] duty,
                               input logic [31:0] delta, input logic [31:0] stall,
                               input logic [31:0] grace, input logic [31:0] release_ms,
                               input logic [31:0] close_tmo, input logic [31:0] open_tmo);
        write_reg(REG_OPEN_DIR, {31'd0, dir});
        write_reg(REG_RUN_DUTY, duty);
        write_reg(REG_MIN_ENC_DELTA, delta);
        write_reg(REG_STALL_TMO, stall);
        write_reg(REG_START_GRACE, grace);
        write_reg(REG_RELEASE_TMO, release_ms);
        write_reg(REG_CLOSE_TMO, close_tmo);
        write_reg(REG_OPEN_TMO, open_tmo);
    endtask

    // walks every healthy mode with the reset configuration; elapsed time crosses the wrap
    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        dir_tick(CMD_LAST_BAD, 1'b0, LIM_LAST_BAD, 32'd0, 10, 1'b1);
        dir_tick(CMD_FIRST_BAD, 1'b0, LIM_CONFLICT, 32'd0, 10, 1'b0);
        dir_tick(CMD_NONE, 1'b1, LIM_NONE, 32'd0, 10, 1'b1);
        dir_tick(CMD_CLEAR, 1'b1, LIM_NONE, 32'd0, 10, 1'b1);
        dir_tick(CMD_STOP, 1'b1, LIM_NONE, 32'd0, 10, 1'b1);
        dir_tick(CMD_NONE, 1'b0, LIM_FIRST_BAD, 32'd0, 10, 1'b0);
        dir_tick(CMD_OPEN, 1'b1, LIM_NONE, 32'h7FFF_FFFF, 10, 1'b1);
        // invalid limit code while moving counts as no switch
        dir_tick(CMD_OPEN, 1'b1, LIM_FIRST_BAD, 32'h7FFF_FFFF, 100, 1'b1);
        dir_tick(CMD_CLEAR, 1'b1, LIM_NONE, 32'h8000_0000, 150, 1'b1);
        dir_tick(CMD_NONE, 1'b1, LIM_CLOSE, 32'h8000_0005, 150, 1'b1);
        dir_tick(CMD_NONE, 1'b0, LIM_OPEN, 32'h8000_0005, 100, 1'b1);
        dir_tick(CMD_CLOSE, 1'b1, LIM_NONE, 32'h8000_0010, 50, 1'b1);
        dir_tick(CMD_CLOSE, 1'b1, LIM_NONE, 32'd5, 10, 1'b1);
        dir_tick(CMD_NONE, 1'b1, LIM_CLOSE, 32'd5, 100, 1'b1);
        dir_tick(CMD_STOP, 1'b1, LIM_CLOSE, 32'd5, 10, 1'b1);
        dir_tick(CMD_CLEAR, 1'b1, LIM_CLOSE, 32'd5, 10, 1'b0);
        dir_tick(CMD_NONE, 1'b0, LIM_NONE, 32'd5, 10, 1'b1);
        dir_tick(CMD_OPEN, 1'b1, LIM_CLOSE, 32'hFFFF_FFFD, 10, 1'b1);
        dir_tick(CMD_NONE, 1'b1, LIM_OPEN, 32'hFFFF_FFFD, 300, 1'b1);
        dir_tick(CMD_CLOSE, 1'b1, LIM_OPEN, 32'd0, 20, 1'b1);
        dir_tick(CMD_STOP, 1'b1, LIM_NONE, 32'd0, 20, 1'b1);
        dir_tick(CMD_NONE, 1'b1, LIM_NONE, 32'd0, 20, 1'b1);
        wait_quiet();
    endtask

    task automatic test_steady_flow();
        idle_pct  = 0;
        stall_pct = 0;
        load_config(1'b1, 32'd100, 32'd1, 32'd300, 32'd100, 32'd400, 32'd6000, 32'd8000);
        run_ticks(100, 1'b1);
        wait_quiet();
    endtask

    // duty above the limit and every threshold at its maximum
    task automatic test_sender_gaps();
        idle_pct  = 77;
        stall_pct = 0;
        load_config(1'b0, 32'h7F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_ticks(100, 1'b1);
        wait_quiet();
    endtask

    // zero duty and zero thresholds, but for the open timeout
    task automatic test_receiver_stalls();
        idle_pct  = 0;
        stall_pct = 77;
        load_config(1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd3000);
        run_ticks(100, 1'b1);
        wait_quiet();
    endtask

    task automatic test_mixed_gaps();
        idle_pct  = 22;
        stall_pct = 22;
        load_config(1'($urandom_range(0, 1)), $urandom_range(1, 100), $urandom_range(1, 20),
                    $urandom_range(100, 800), $urandom_range(0, 400),
                    $urandom_range(100, 2000), $urandom_range(1000, 20000),
                    $urandom_range(1000, 20000));
        run_ticks(50, 1'b1);
        // hold the sender until every result is back
        wait_quiet();
        run_ticks(50, 1'b1);
        wait_quiet();
    endtask

    // unguarded ticks can drive the block into its latched fault, then raw noise follows
    task automatic test_fault_tail();
        tick_t t;
        idle_pct  = 22;
        stall_pct = 22;
        run_ticks(15, 1'b0);
        repeat (25) begin
            @(negedge aclk);
            t         = random_tick();
            t.cmd     = CMD_W'($urandom_range(CMD_NONE, CMD_LAST_BAD));
            t.lc      = LIMIT_W'($urandom_range(LIM_NONE, LIM_LAST_BAD));
            t.read_ok = 1'($urandom_range(0, 1));
            t.settled = 1'($urandom_range(0, 1));
            t.enc_ok  = 1'($urandom_range(0, 1));
            t.drv_ok  = 1'($urandom_range(0, 1));
            t.enc     = $urandom;
            push_tick(t);
        end
        wait_quiet();
    endtask

    initial begin
        fsm_model.mode         = MD_INIT;
        fsm_model.fault        = F_NONE;
        fsm_model.motion_start = '0;
        fsm_model.last_move    = '0;
        fsm_model.ref_pos      = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_steady_flow();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_gaps();
        test_fault_tail();
        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/atsf_pkg.sv
rtl/core/actuator_travel_safety_fsm.sv
test/tb.sv
